[design/pbcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pairwise box collision filter package
// Shared constants, command codes and reset values of the collision filter.
// ----------------------------------------------------------------------------
package pbcf_pkg;

	// Default sizing of the box table.
	localparam int ENTRIES_DEF    = 16;
	localparam int COORD_BITS_DEF = 16;

	// Fixed field widths of the request and result channels.
	localparam int CMD_W   = 2;
	localparam int SLOT_W  = 4;
	localparam int SIZE_W  = 15;
	localparam int KIND_W  = 3;

	// Request commands.
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;

	// Upper bound on reports of one sweep and the width of its counter.
	localparam int REPORT_CNT_W = 5;
	localparam logic [REPORT_CNT_W-1:0] MAX_REPORTS = 5'd30;

	// Kind-pair filter matrix.
	localparam int MATRIX_W = 64;
	localparam logic [MATRIX_W-1:0] MATRIX_RESET = 64'h52A6_56AE_F0F0_F000;

	// Configuration register byte addresses.
	localparam int PADDR_W = 4;
	localparam logic [PADDR_W-1:0] ADDR_MATRIX = 4'h0;

endpackage
`default_nettype wire

[design/pairwise_box_collision_filter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// A write, remove or ignored request goes from the idle state to the finish state, which registers its one result.
// A sweep of slot i loads box i, then steps the shared comparator through every later slot,
// staying on a slot for the second direction of a pair reported both ways, then registers the final result.
// One request at a time: no new request is taken until the final result of the last one is registered;
// a new report or the final result waits while the output register is full and not taken.
// Reset clears all valid bits and loads the filter matrix with its default value.
// ----------------------------------------------------------------------------
// Pairwise box collision filter
// Keeps a table of axis-aligned boxes and, on a sweep request, compares one box
// with every valid later slot through a single shared overlap comparator,
// reporting each allowed (receiver, other) pair, up to MAX_REPORTS, on the result stream.
// ----------------------------------------------------------------------------
module pairwise_box_collision_filter_core #(
	parameter int ENTRIES    = pbcf_pkg::ENTRIES_DEF,
	parameter int COORD_BITS = pbcf_pkg::COORD_BITS_DEF,
	localparam int IN_BITS   = pbcf_pkg::SLOT_W + 2 * COORD_BITS + 2 * pbcf_pkg::SIZE_W
		+ pbcf_pkg::KIND_W + 1,
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Request stream.
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// s_tdata: slot, pos_x, pos_y, width, height, kind, notify_enabled, zero fill
	input  wire logic [IN_DATA_W-1:0]          s_tdata,
	// s_tuser: command
	input  wire logic [pbcf_pkg::CMD_W-1:0]    s_tuser,
	// Result stream.
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// m_tdata: receiver, other
	output      logic [2*pbcf_pkg::SLOT_W-1:0] m_tdata,
	// m_tuser: hit
	output      logic                          m_tuser,
	output      logic                          m_tlast,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pbcf_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [pbcf_pkg::MATRIX_W-1:0] pwdata,
	output      logic [pbcf_pkg::MATRIX_W-1:0] prdata,
	output      logic                          pready
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = IDX_W + 1;
	localparam int SUM_W  = ((COORD_BITS > pbcf_pkg::SIZE_W) ? COORD_BITS : pbcf_pkg::SIZE_W) + 2;

	// Field offsets inside s_tdata.
	localparam int OFS_X    = pbcf_pkg::SLOT_W;
	localparam int OFS_Y    = OFS_X + COORD_BITS;
	localparam int OFS_W    = OFS_Y + COORD_BITS;
	localparam int OFS_H    = OFS_W + pbcf_pkg::SIZE_W;
	localparam int OFS_KIND = OFS_H + pbcf_pkg::SIZE_W;
	localparam int OFS_NTFY = OFS_KIND + pbcf_pkg::KIND_W;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOADI  = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	typedef struct packed {
		logic [COORD_BITS-1:0]        x;
		logic [COORD_BITS-1:0]        y;
		logic [pbcf_pkg::SIZE_W-1:0]  w;
		logic [pbcf_pkg::SIZE_W-1:0]  h;
		logic [pbcf_pkg::KIND_W-1:0]  kind;
		logic                         notify;
	} box_t;

	typedef struct packed {
		logic [pbcf_pkg::SLOT_W-1:0] receiver;
		logic [pbcf_pkg::SLOT_W-1:0] other;
	} report_t;

	// Storage.
	box_t                          box_mem [ENTRIES];
	box_t                          rd_q;
	box_t                          boxi_q;
	logic [ENTRIES-1:0]            valid_q;
	logic [pbcf_pkg::MATRIX_W-1:0] matrix_q;

	// Sequencer registers.
	logic [1:0]                        state_q;
	logic [IDX_W-1:0]                  i_q;
	logic [CNT_W-1:0]                  j_q;
	logic                              dir1_q;
	logic [pbcf_pkg::REPORT_CNT_W-1:0] cnt_q;
	logic                              pend_valid_q;
	report_t                           pend_q;

	// Output register.
	logic                          out_valid_q;
	report_t                       out_data_q;
	logic                          out_hit_q;
	logic                          out_last_q;

	// Request field decode.
	logic [pbcf_pkg::SLOT_W-1:0] in_slot;
	logic [IDX_W-1:0]            in_idx;
	logic                        in_range;
	logic                        accept;
	box_t                        in_box;

	// Comparator and scan control.
	logic signed [SUM_W-1:0] xi, yi, wi, hi, xj, yj, wj, hj;
	logic                    overlap;
	logic                    r0, r1, rep, stay, place, stall, out_free;
	report_t                 rep_data;
	logic [CNT_W-1:0]        j_next;
	logic [CNT_W-1:0]        i_next;
	logic [IDX_W-1:0]        rd_addr;

	// Request field extraction.
	assign in_slot  = s_tdata[pbcf_pkg::SLOT_W-1:0];
	assign in_idx   = IDX_W'(CNT_W'(in_slot));
	assign in_range = int'(in_slot) < ENTRIES;
	assign in_box.x      = s_tdata[OFS_X +: COORD_BITS];
	assign in_box.y      = s_tdata[OFS_Y +: COORD_BITS];
	assign in_box.w      = s_tdata[OFS_W +: pbcf_pkg::SIZE_W];
	assign in_box.h      = s_tdata[OFS_H +: pbcf_pkg::SIZE_W];
	assign in_box.kind   = s_tdata[OFS_KIND +: pbcf_pkg::KIND_W];
	assign in_box.notify = s_tdata[OFS_NTFY];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Shared overlap comparator: box i against the box fetched for slot j.
	always_comb begin
		xi = SUM_W'($signed(boxi_q.x));
		yi = SUM_W'($signed(boxi_q.y));
		wi = $signed(SUM_W'(boxi_q.w));
		hi = $signed(SUM_W'(boxi_q.h));
		xj = SUM_W'($signed(rd_q.x));
		yj = SUM_W'($signed(rd_q.y));
		wj = $signed(SUM_W'(rd_q.w));
		hj = $signed(SUM_W'(rd_q.h));
		overlap = (xi < xj + wj) && (xi + wi > xj) && (yi < yj + hj) && (yi + hi > yj);
	end

	// Report decision for the current pair; a pair allowed both ways is reported in each direction, holding the slot.
	always_comb begin
		logic ok;
		ok    = overlap && valid_q[j_q[IDX_W-1:0]];
		r0    = ok && !dir1_q && boxi_q.notify && matrix_q[{boxi_q.kind, rd_q.kind}];
		r1    = ok && rd_q.notify && matrix_q[{rd_q.kind, boxi_q.kind}];
		rep   = r0 || r1;
		stay  = r0 && r1;
		place = rep && (cnt_q < pbcf_pkg::MAX_REPORTS);
		stall = place && pend_valid_q && !out_free;
		if (r0) begin
			rep_data.receiver = pbcf_pkg::SLOT_W'(i_q);
			rep_data.other    = pbcf_pkg::SLOT_W'(j_q);
		end else begin
			rep_data.receiver = pbcf_pkg::SLOT_W'(j_q);
			rep_data.other    = pbcf_pkg::SLOT_W'(i_q);
		end
	end

	assign j_next = j_q + CNT_W'(1);
	assign i_next = CNT_W'(i_q) + CNT_W'(1);

	// Read address of the box memory.
	always_comb begin
		unique case (state_q)
			ST_IDLE:  rd_addr = in_idx;
			ST_LOADI: rd_addr = i_next[IDX_W-1:0];
			ST_SCAN: begin
				if (stall || stay) begin
					rd_addr = j_q[IDX_W-1:0];
				end else begin
					rd_addr = j_next[IDX_W-1:0];
				end
			end
			default:  rd_addr = j_q[IDX_W-1:0];
		endcase
	end

	// Box memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && in_range && s_tuser == pbcf_pkg::CMD_WRITE) begin
			box_mem[in_idx] <= in_box;
		end
		rd_q <= box_mem[rd_addr];
	end

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[3] == pbcf_pkg::ADDR_MATRIX[3]) ? matrix_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= pbcf_pkg::MATRIX_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[3] == pbcf_pkg::ADDR_MATRIX[3]) begin
			matrix_q <= pwdata;
		end
	end

	// Valid bits of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && in_range) begin
			if (s_tuser == pbcf_pkg::CMD_WRITE) begin
				valid_q[in_idx] <= 1'b1;
			end else if (s_tuser == pbcf_pkg::CMD_REMOVE) begin
				valid_q[in_idx] <= 1'b0;
			end
		end
	end

	// Sweep operand and pending report registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			i_q <= in_idx;
		end
		if (state_q == ST_LOADI) begin
			boxi_q <= rd_q;
		end
		if (state_q == ST_SCAN && place && !stall) begin
			pend_q <= rep_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			j_q          <= '0;
			dir1_q       <= 1'b0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q        <= '0;
					pend_valid_q <= 1'b0;
					dir1_q       <= 1'b0;
					if (accept) begin
						if (in_range && s_tuser == pbcf_pkg::CMD_SWEEP && valid_q[in_idx]) begin
							state_q <= ST_LOADI;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_LOADI: begin
					j_q <= i_next;
					if (i_next == CNT_W'(ENTRIES)) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (place) begin
							pend_valid_q <= 1'b1;
							cnt_q        <= cnt_q + pbcf_pkg::REPORT_CNT_W'(1);
						end
						if (stay) begin
							dir1_q <= 1'b1;
						end else begin
							dir1_q <= 1'b0;
							j_q    <= j_next;
							if (j_next == CNT_W'(ENTRIES)) begin
								state_q <= ST_FINISH;
							end
						end
					end
				end
				default: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Output register: a displaced pending report leaves with last low, the final one with last high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_SCAN && place && pend_valid_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && place && pend_valid_q && out_free) begin
			out_data_q <= pend_q;
			out_hit_q  <= 1'b1;
			out_last_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_data_q <= pend_valid_q ? pend_q : '0;
			out_hit_q  <= pend_valid_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_data_q.other, out_data_q.receiver};
	assign m_tuser  = out_hit_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

[sim/tb_pairwise_box_collision_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise box collision filter testbench
// Drives write, remove and sweep requests into the box table, mirrors the
// table and the kind filter in a local predictor, and compares every result
// on the output stream with the predicted reports. The run steps through
// several filter settings and idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module tb_pairwise_box_collision_filter_core;
	import pbcf_pkg::*;

	localparam int SLOTS = ENTRIES_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [KIND_W-1:0] kind;
		logic              notify;
	} request_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] receiver;
		logic [SLOT_W-1:0] other;
		logic              last;
	} report_t;

	// A directed step either expects the plain acknowledgement or asks the predictor.
	typedef struct packed {
		logic     ack_only;
		request_t req;
	} step_t;

	localparam int N_DIRECTED = 23;
	localparam step_t DIRECTED [N_DIRECTED] = '{
		'{1'b1, '{CMD_SWEEP,  4'd0,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_REMOVE, 4'd15, 16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_UNUSED, 4'd5,  -16'sd1,     -16'sd1,     15'd32767, 15'd32767, 3'd7, 1'b1}},
		'{1'b1, '{CMD_WRITE,  4'd0,  -16'sd32768, -16'sd32768, 15'd32767, 15'd32767, 3'd1, 1'b1}},
		'{1'b1, '{CMD_WRITE,  4'd1,  -16'sd100,   -16'sd100,   15'd200,   15'd200,   3'd4, 1'b1}},
		'{1'b1, '{CMD_WRITE,  4'd2,  16'sd32767,  16'sd32767,  15'd32767, 15'd32767, 3'd7, 1'b1}},
		'{1'b1, '{CMD_WRITE,  4'd15, 16'sd0,      16'sd0,      15'd0,     15'd0,     3'd5, 1'b1}},
		'{1'b0, '{CMD_SWEEP,  4'd0,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b0, '{CMD_SWEEP,  4'd1,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_SWEEP,  4'd15, 16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_WRITE,  4'd3,  -16'sd50,    -16'sd50,    15'd10,    15'd10,    3'd0, 1'b0}},
		'{1'b0, '{CMD_SWEEP,  4'd1,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_WRITE,  4'd1,  -16'sd100,   -16'sd100,   15'd200,   15'd200,   3'd4, 1'b0}},
		'{1'b0, '{CMD_SWEEP,  4'd0,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_REMOVE, 4'd0,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_SWEEP,  4'd0,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_WRITE,  4'd14, 16'sd100,    -16'sd100,   15'd10,    15'd10,    3'd5, 1'b1}},
		'{1'b0, '{CMD_SWEEP,  4'd1,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_WRITE,  4'd4,  -16'sd10,    -16'sd10,    15'd20,    15'd20,    3'd7, 1'b1}},
		'{1'b0, '{CMD_SWEEP,  4'd3,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b0, '{CMD_SWEEP,  4'd1,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}},
		'{1'b1, '{CMD_WRITE,  4'd13, -16'sd10,    -16'sd10,    15'd20,    15'd20,    3'd6, 1'b1}},
		'{1'b0, '{CMD_SWEEP,  4'd4,  16'sd0,      16'sd0,      15'd0,     15'd0,     3'd0, 1'b0}}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata: slot, pos_x, pos_y, width, height, kind, notify_enabled, zero fill
	logic [71:0]           s_tdata;
	// s_tuser: command
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata: receiver, other
	logic [2*SLOT_W-1:0]   m_tdata;
	// m_tuser: hit
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [MATRIX_W-1:0]   pwdata;
	logic [MATRIX_W-1:0]   prdata;
	logic                  pready;

	// Mirror of the box table and the kind filter.
	logic [MATRIX_W-1:0] filter_matrix;
	logic signed [15:0]  tab_x [SLOTS];
	logic signed [15:0]  tab_y [SLOTS];
	logic [SIZE_W-1:0]   tab_w [SLOTS];
	logic [SIZE_W-1:0]   tab_h [SLOTS];
	logic [KIND_W-1:0]   tab_kind [SLOTS];
	logic                tab_notify [SLOTS];
	logic                tab_valid [SLOTS];

	report_t pending_reports [$];

	int errors = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int settings_used = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	pairwise_box_collision_filter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("** pairwise_box_collision_filter_core: FAILED **");
		$finish;
	end

	// Strict overlap on both axes; sums are wide enough that nothing wraps.
	function automatic bit boxes_meet(int a, int b);
		int ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
		ax0 = int'(tab_x[a]);
		ay0 = int'(tab_y[a]);
		ax1 = ax0 + int'(tab_w[a]);
		ay1 = ay0 + int'(tab_h[a]);
		bx0 = int'(tab_x[b]);
		by0 = int'(tab_y[b]);
		bx1 = bx0 + int'(tab_w[b]);
		by1 = by0 + int'(tab_h[b]);
		return ax0 < bx1 && ax1 > bx0 && ay0 < by1 && ay1 > by0;
	endfunction

	// Updates the table mirror and, if asked, queues the results the request causes.
	function automatic void apply_request(request_t r, bit record);
		logic [SLOT_W-1:0] recv_list [$];
		logic [SLOT_W-1:0] oth_list [$];
		int s;
		s = int'(r.slot);
		case (r.cmd)
			CMD_WRITE: begin
				tab_x[s] = r.x;
				tab_y[s] = r.y;
				tab_w[s] = r.w;
				tab_h[s] = r.h;
				tab_kind[s] = r.kind;
				tab_notify[s] = r.notify;
				tab_valid[s] = 1'b1;
			end
			CMD_REMOVE: tab_valid[s] = 1'b0;
			CMD_SWEEP: begin
				if (tab_valid[s]) begin
					for (int j = s + 1; j < SLOTS; j++) begin
						if (tab_valid[j] && boxes_meet(s, j)) begin
							if (tab_notify[s] && filter_matrix[{tab_kind[s], tab_kind[j]}]
								&& recv_list.size() < int'(MAX_REPORTS)) begin
								recv_list.push_back(SLOT_W'(s));
								oth_list.push_back(SLOT_W'(j));
							end
							if (tab_notify[j] && filter_matrix[{tab_kind[j], tab_kind[s]}]
								&& recv_list.size() < int'(MAX_REPORTS)) begin
								recv_list.push_back(SLOT_W'(j));
								oth_list.push_back(SLOT_W'(s));
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (!record)
			return;
		if (recv_list.size() == 0)
			pending_reports.push_back('{1'b0, '0, '0, 1'b1});
		else
			for (int k = 0; k < recv_list.size(); k++)
				pending_reports.push_back('{1'b1, recv_list[k], oth_list[k],
					k == recv_list.size() - 1});
	endfunction

	// Random requests: mostly writes and sweeps in a crowded area, with some full-range noise.
	function automatic request_t random_request();
		request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 42)
			r.cmd = CMD_WRITE;
		else if (pick < 55)
			r.cmd = CMD_REMOVE;
		else if (pick < 95)
			r.cmd = CMD_SWEEP;
		else
			r.cmd = CMD_UNUSED;
		if (r.cmd == CMD_SWEEP && $urandom_range(0, 1) == 1)
			r.slot = SLOT_W'($urandom_range(0, 5));
		else
			r.slot = SLOT_W'($urandom_range(0, 15));
		if ($urandom_range(0, 3) == 0) begin
			r.x = 16'($urandom);
			r.y = 16'($urandom);
			r.w = SIZE_W'($urandom);
			r.h = SIZE_W'($urandom);
		end else begin
			r.x = 16'($urandom_range(0, 800) - 400);
			r.y = 16'($urandom_range(0, 800) - 400);
			r.w = SIZE_W'($urandom_range(0, 500));
			r.h = SIZE_W'($urandom_range(0, 500));
		end
		r.kind = KIND_W'($urandom);
		r.notify = $urandom_range(0, 4) != 0;
		return r;
	endfunction

	// Offers one request after a random gap and returns at the edge that accepts it.
	task automatic send_request(input request_t r);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {2'b00, r.notify, r.kind, r.h, r.w, r.y, r.x, r.slot};
		do @(posedge clk); while (!s_tready);
		requests_sent++;
	endtask

	// Lets every outstanding result arrive, then a few quiet cycles.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_check(input logic [MATRIX_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_MATRIX;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("collision_matrix readback: expected %h, got %h", value, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [MATRIX_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MATRIX;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		filter_matrix = value;
		settings_used++;
		cfg_check(value);
	endtask

	// One random phase: new filter setting, new idle pattern, optional long receiver hold.
	task automatic run_phase(input logic [MATRIX_W-1:0] matrix, input int send_pct,
		input int stall_pct, input int count, input bit squeeze);
		request_t r;
		settle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_write(matrix);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		if (squeeze)
			hold_req++;
		repeat (count) begin
			r = random_request();
			send_request(r);
			apply_request(r, 1'b1);
		end
	endtask

	// Receiver side: random stalls, plus a long hold when the sender asks for one.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_seen <= hold_req;
		end else begin
			m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser)
				hits_seen++;
			if (pending_reports.size() == 0) begin
				$error("unexpected result: hit %0d receiver %0d other %0d last %0d",
					m_tuser, m_tdata[3:0], m_tdata[7:4], m_tlast);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (m_tuser !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, m_tuser);
					errors++;
				end
				if (m_tdata[3:0] !== want.receiver) begin
					$error("receiver: expected %0d, got %0d", want.receiver, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[7:4] !== want.other) begin
					$error("other: expected %0d, got %0d", want.other, m_tdata[7:4]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random phases.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_MATRIX;
		pwdata = '0;
		filter_matrix = MATRIX_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			tab_x[i] = '0;
			tab_y[i] = '0;
			tab_w[i] = '0;
			tab_h[i] = '0;
			tab_kind[i] = '0;
			tab_notify[i] = 1'b0;
			tab_valid[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		cfg_check(MATRIX_RESET);

		// Directed table under the reset filter, no idling.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(DIRECTED[i].req);
			apply_request(DIRECTED[i].req, !DIRECTED[i].ack_only);
			if (DIRECTED[i].ack_only)
				pending_reports.push_back('{1'b0, '0, '0, 1'b1});
		end

		run_phase('1, 0, 0, 41, 1'b0);
		run_phase({$urandom, $urandom}, 83, 0, 41, 1'b0);
		run_phase('0, 0, 83, 41, 1'b0);
		run_phase(MATRIX_RESET, 0, 0, 41, 1'b1);
		run_phase({$urandom, $urandom}, 38, 38, 41, 1'b0);
		run_phase({$urandom, $urandom}, 38, 38, 41, 1'b1);
		settle();

		if (pending_reports.size() != 0) begin
			$error("%0d expected results never arrived", pending_reports.size());
			errors++;
		end
		$display("Run covered %0d requests and %0d results, %0d of them collision reports,",
			requests_sent, results_seen, hits_seen);
		$display("across %0d filter settings with idle, stall and back-pressure phases.",
			settings_used);
		if (errors == 0)
			$display("** pairwise_box_collision_filter_core: PASSED **");
		else
			$display("** pairwise_box_collision_filter_core: FAILED **");
		$finish;
	end

endmodule
